// ===== design/cha_pkg.sv =====
// Package for the contiguous hole allocator: field widths, command, fit-mode and
// register codes, the sequencer state type and the fit unit control struct.
// No dependencies.
package cha_pkg;

   // Default sizing of the hole table.
   localparam int MAX_HOLES_DEF = 16;
   localparam int SIZE_BITS_DEF = 16;

   // Fixed widths of the item and result fields.
   localparam int CMD_W   = 2;
   localparam int IDX_W   = 4;
   localparam int VAL_W   = 16;

   // Configuration register widths and port widths.
   localparam int MODE_W     = 2;
   localparam int HCNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

   // Fit modes; the unused code behaves as first fit.
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLE_COUNT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESTORE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic              clear;
      logic              sample;
      logic [MODE_W-1:0] mode;
   } fit_ctl_type;

endpackage

// ===== design/cha_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Used for both the current and the original hole size tables; no dependencies.
module cha_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cha_fit.sv =====
// Fit selection unit: tracks the chosen hole over one scan of the size table.
// Depends on cha_pkg for the fit modes and the control struct.
module cha_fit #(
   parameter int MAX_HOLES = cha_pkg::MAX_HOLES_DEF,
   parameter int SIZE_BITS = cha_pkg::SIZE_BITS_DEF,
   localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cha_pkg::fit_ctl_type ctl,
   input  logic [SIZE_BITS-1:0] req_size,
   input  logic [AW-1:0]        cand_idx,
   input  logic [SIZE_BITS-1:0] cand_size,
   output logic                 found,
   output logic [AW-1:0]        pick,
   output logic [SIZE_BITS-1:0] best
);

   logic                 found_ff, found_in;
   logic [AW-1:0]        pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic                 fits;
   logic                 better;
   logic                 take;

   always_comb begin
      fits = (cand_size >= req_size);
      case (ctl.mode)
         cha_pkg::FIT_BEST:  better = (cand_size < best_ff);
         cha_pkg::FIT_WORST: better = (cand_size > best_ff);
         default:            better = 1'b0;
      endcase
      take = ctl.sample && fits && (!found_ff || better);

      found_in = found_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         pick_in  = cand_idx;
         best_in  = cand_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      best_ff <= best_in;
   end

   assign found = found_ff;
   assign pick  = pick_ff;
   assign best  = best_ff;

endmodule

// ===== design/cha_ctrl.sv =====
// Sequencer of the hole allocator: configuration registers, command decode,
// table sweeps, write-back and the result register. Depends on cha_pkg.
module cha_ctrl #(
   parameter int MAX_HOLES = cha_pkg::MAX_HOLES_DEF,
   parameter int SIZE_BITS = cha_pkg::SIZE_BITS_DEF,
   localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1,
   localparam int CW = $clog2(MAX_HOLES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [cha_pkg::CMD_W-1:0]       req_command,
   input  logic [cha_pkg::IDX_W-1:0]       req_hole_index,
   input  logic [cha_pkg::VAL_W-1:0]       req_size_value,
   // Result channel.
   output logic                            rsp_valid,
   output logic                            rsp_granted,
   output logic [cha_pkg::IDX_W-1:0]       rsp_hole_number,
   output logic [cha_pkg::VAL_W-1:0]       rsp_remaining_size,
   // Configuration channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cha_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cha_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Table memories.
   output logic                            cur_we,
   output logic [AW-1:0]                   cur_waddr,
   output logic [SIZE_BITS-1:0]            cur_wdata,
   input  logic [SIZE_BITS-1:0]            cur_rdata,
   output logic                            orig_we,
   output logic [AW-1:0]                   orig_waddr,
   output logic [SIZE_BITS-1:0]            orig_wdata,
   input  logic [SIZE_BITS-1:0]            orig_rdata,
   output logic [AW-1:0]                   rd_addr,
   // Fit unit.
   output cha_pkg::fit_ctl_type            fit_ctl,
   output logic [SIZE_BITS-1:0]            req_size,
   output logic [AW-1:0]                   cand_idx,
   output logic [SIZE_BITS-1:0]            cand_size,
   input  logic                            found,
   input  logic [AW-1:0]                   pick,
   input  logic [SIZE_BITS-1:0]            best
);

   cha_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [CW-1:0]                   limit_ff, limit_in;
   logic [SIZE_BITS-1:0]            size_ff, size_in;
   logic                            tag_vld_ff, tag_vld_in;
   logic                            tag_rst_ff, tag_rst_in;
   logic [AW-1:0]                   tag_idx_ff, tag_idx_in;
   logic [cha_pkg::MODE_W-1:0]      fit_mode_ff, fit_mode_in;
   logic [cha_pkg::HCNT_W-1:0]      hole_count_ff, hole_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_granted_ff, rsp_granted_in;
   logic [cha_pkg::IDX_W-1:0]       rsp_number_ff, rsp_number_in;
   logic [cha_pkg::VAL_W-1:0]       rsp_remain_ff, rsp_remain_in;

   logic                            accept;
   logic                            last;
   logic                            load_ok;
   logic [CW-1:0]                   count_sat;
   logic [SIZE_BITS-1:0]            remain_full;
   logic                            csr_write;

   assign busy      = (state_ff != cha_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign last      = ((cnt_ff + CW'(1)) == limit_ff);
   assign load_ok   = (32'(req_hole_index) < MAX_HOLES);

   // Hole counts above the table depth search the whole table.
   always_comb begin
      if (32'(hole_count_ff) > MAX_HOLES) begin
         count_sat = CW'(MAX_HOLES);
      end else begin
         count_sat = CW'(hole_count_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cha_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  cha_pkg::CMD_RESTORE: state_in = cha_pkg::ST_RESTORE;
                  cha_pkg::CMD_ALLOC: begin
                     if (count_sat == '0) begin
                        state_in = cha_pkg::ST_COMMIT;
                     end else begin
                        state_in = cha_pkg::ST_SCAN;
                     end
                  end
                  default: state_in = cha_pkg::ST_IDLE;
               endcase
            end
         end
         cha_pkg::ST_RESTORE: begin
            if (last) begin
               state_in = cha_pkg::ST_DRAIN;
            end
         end
         cha_pkg::ST_SCAN: begin
            if (last) begin
               state_in = cha_pkg::ST_DRAIN;
            end
         end
         cha_pkg::ST_DRAIN:  state_in = cha_pkg::ST_COMMIT;
         cha_pkg::ST_COMMIT: state_in = cha_pkg::ST_IDLE;
         default:            state_in = cha_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      cnt_in        = cnt_ff;
      limit_in      = limit_ff;
      size_in       = size_ff;
      fit_mode_in   = fit_mode_ff;
      hole_count_in = hole_count_ff;

      cur_we     = 1'b0;
      cur_waddr  = tag_idx_ff;
      cur_wdata  = orig_rdata;
      orig_we    = 1'b0;
      orig_waddr = AW'(req_hole_index);
      orig_wdata = SIZE_BITS'(req_size_value);

      tag_vld_in = (state_ff == cha_pkg::ST_SCAN) || (state_ff == cha_pkg::ST_RESTORE);
      tag_rst_in = (state_ff == cha_pkg::ST_RESTORE);
      tag_idx_in = cnt_ff[AW-1:0];

      remain_full    = best - size_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = 1'b0;
      rsp_number_in  = '0;
      rsp_remain_in  = '0;

      if (accept) begin
         cnt_in  = '0;
         size_in = SIZE_BITS'(req_size_value);
         if (req_command == cha_pkg::CMD_RESTORE) begin
            limit_in = CW'(MAX_HOLES);
         end else begin
            limit_in = count_sat;
         end
         if (req_command inside {cha_pkg::CMD_LOAD, cha_pkg::CMD_UNUSED}) begin
            rsp_valid_in = 1'b1;
         end
         if ((req_command == cha_pkg::CMD_LOAD) && load_ok) begin
            cur_we    = 1'b1;
            cur_waddr = AW'(req_hole_index);
            cur_wdata = SIZE_BITS'(req_size_value);
            orig_we   = 1'b1;
         end
      end

      if ((state_ff == cha_pkg::ST_SCAN) || (state_ff == cha_pkg::ST_RESTORE)) begin
         cnt_in = cnt_ff + CW'(1);
      end

      // Restore write-back: original data arrives in the cycle after its read.
      if (tag_vld_ff && tag_rst_ff) begin
         cur_we    = 1'b1;
         cur_waddr = tag_idx_ff;
         cur_wdata = orig_rdata;
      end

      if (state_ff == cha_pkg::ST_COMMIT) begin
         rsp_valid_in = 1'b1;
         if (found) begin
            cur_we         = 1'b1;
            cur_waddr      = pick;
            cur_wdata      = remain_full;
            rsp_granted_in = 1'b1;
            rsp_number_in  = cha_pkg::IDX_W'(pick);
            rsp_remain_in  = cha_pkg::VAL_W'(remain_full);
         end
      end

      if (csr_write) begin
         case (csr_index)
            cha_pkg::CSR_FIT_MODE:   fit_mode_in   = cha_pkg::MODE_W'(csr_wdata);
            cha_pkg::CSR_HOLE_COUNT: hole_count_in = cha_pkg::HCNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign rd_addr        = cnt_ff[AW-1:0];
   assign fit_ctl.clear  = accept;
   assign fit_ctl.sample = tag_vld_ff && !tag_rst_ff;
   assign fit_ctl.mode   = fit_mode_ff;
   assign req_size       = size_ff;
   assign cand_idx       = tag_idx_ff;
   assign cand_size      = cur_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cha_pkg::ST_IDLE;
         cnt_ff        <= '0;
         tag_vld_ff    <= 1'b0;
         tag_rst_ff    <= 1'b0;
         fit_mode_ff   <= cha_pkg::FIT_FIRST;
         hole_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         tag_vld_ff    <= tag_vld_in;
         tag_rst_ff    <= tag_rst_in;
         fit_mode_ff   <= fit_mode_in;
         hole_count_ff <= hole_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff       <= limit_in;
      size_ff        <= size_in;
      tag_idx_ff     <= tag_idx_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_remain_ff  <= rsp_remain_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_hole_number    = rsp_number_ff;
   assign rsp_remaining_size = rsp_remain_ff;

endmodule

// ===== design/contiguous_hole_allocator_top.sv =====
// Top level of the contiguous hole allocator (first, best and worst fit).
// Depends on cha_pkg, cha_ram, cha_fit and cha_ctrl.
//
//   Channel   Ports                                          Direction  Handshake
//   request   req_command, req_hole_index, req_size_value    in         start / busy
//   response  rsp_granted, rsp_hole_number,                  out        rsp_valid strobe
//             rsp_remaining_size
//   config    csr_index, csr_wdata                           in         csr_valid / csr_ready
//
// An item is taken when start is high and busy is low. A load item writes both size
// tables at that edge and its result strobes on the next cycle. A restore item sweeps
// all MAX_HOLES entries, one per cycle, through the single read port of the original
// table; its result strobes once the sweep has passed the drain and commit states.
// An allocate item scans the counted holes one per cycle through the read port of
// the current table, then passes the drain and commit states; a count of zero goes
// straight to commit. Reset is synchronous, active high, and clears fit_mode and
// hole_count; the size tables hold nothing until loaded. Each result is shown for
// exactly one cycle and the next item may be taken in that same cycle.
module contiguous_hole_allocator_top #(
   parameter int MAX_HOLES = cha_pkg::MAX_HOLES_DEF,
   parameter int SIZE_BITS = cha_pkg::SIZE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cha_pkg::CMD_W-1:0]       req_command,
   input  logic [cha_pkg::IDX_W-1:0]       req_hole_index,
   input  logic [cha_pkg::VAL_W-1:0]       req_size_value,
   output logic                            rsp_valid,
   output logic                            rsp_granted,
   output logic [cha_pkg::IDX_W-1:0]       rsp_hole_number,
   output logic [cha_pkg::VAL_W-1:0]       rsp_remaining_size,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cha_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cha_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

   // Both tables share one read address: the restore sweep reads the originals
   // and the allocate scan reads the current sizes, never at the same time.
   logic                 cur_we;
   logic [AW-1:0]        cur_waddr;
   logic [SIZE_BITS-1:0] cur_wdata;
   logic [SIZE_BITS-1:0] cur_rdata;
   logic                 orig_we;
   logic [AW-1:0]        orig_waddr;
   logic [SIZE_BITS-1:0] orig_wdata;
   logic [SIZE_BITS-1:0] orig_rdata;
   logic [AW-1:0]        rd_addr;

   cha_pkg::fit_ctl_type fit_ctl;
   logic [SIZE_BITS-1:0] req_size;
   logic [AW-1:0]        cand_idx;
   logic [SIZE_BITS-1:0] cand_size;
   logic                 found;
   logic [AW-1:0]        pick;
   logic [SIZE_BITS-1:0] best;

   // Current hole sizes, shrunk by each granted allocation.
   cha_ram #(
      .DEPTH (MAX_HOLES),
      .WIDTH (SIZE_BITS)
   ) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (rd_addr),
      .rd_data (cur_rdata)
   );

   // Original hole sizes, written only by load items.
   cha_ram #(
      .DEPTH (MAX_HOLES),
      .WIDTH (SIZE_BITS)
   ) u_orig_ram (
      .clock   (clock),
      .wr_en   (orig_we),
      .wr_addr (orig_waddr),
      .wr_data (orig_wdata),
      .rd_addr (rd_addr),
      .rd_data (orig_rdata)
   );

   // Keeps the best candidate seen so far; ties stay with the lower hole.
   cha_fit #(
      .MAX_HOLES (MAX_HOLES),
      .SIZE_BITS (SIZE_BITS)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fit_ctl),
      .req_size  (req_size),
      .cand_idx  (cand_idx),
      .cand_size (cand_size),
      .found     (found),
      .pick      (pick),
      .best      (best)
   );

   cha_ctrl #(
      .MAX_HOLES (MAX_HOLES),
      .SIZE_BITS (SIZE_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_hole_index     (req_hole_index),
      .req_size_value     (req_size_value),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_hole_number    (rsp_hole_number),
      .rsp_remaining_size (rsp_remaining_size),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cur_we             (cur_we),
      .cur_waddr          (cur_waddr),
      .cur_wdata          (cur_wdata),
      .cur_rdata          (cur_rdata),
      .orig_we            (orig_we),
      .orig_waddr         (orig_waddr),
      .orig_wdata         (orig_wdata),
      .orig_rdata         (orig_rdata),
      .rd_addr            (rd_addr),
      .fit_ctl            (fit_ctl),
      .req_size           (req_size),
      .cand_idx           (cand_idx),
      .cand_size          (cand_size),
      .found              (found),
      .pick               (pick),
      .best               (best)
   );

endmodule

// ===== sim/hole_alloc_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the contiguous hole allocator: follows register writes and
// accepted items, predicts each response from its own hole tables and compares it.
// Depends on cha_pkg.
module hole_alloc_checker
   import cha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [IDX_W-1:0]      req_hole_index,
   input  logic [VAL_W-1:0]      req_size_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_granted,
   input  logic [IDX_W-1:0]      rsp_hole_number,
   input  logic [VAL_W-1:0]      rsp_remaining_size,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    responses_seen,
   output int                    grants_seen
);

   localparam int HOLES  = MAX_HOLES_DEF;
   localparam int SIZE_W = SIZE_BITS_DEF;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] hole_number;
      logic [VAL_W-1:0] remaining_size;
   } alloc_rsp_type;

   logic [MODE_W-1:0] fit_mode;
   logic [HCNT_W-1:0] hole_count;
   logic [SIZE_W-1:0] current_size [HOLES];
   logic [SIZE_W-1:0] original_size [HOLES];
   alloc_rsp_type     expected_rsp [$];
   int                fail_tally = 0;
   int                response_tally = 0;
   int                grant_tally = 0;

   // Applies one command to the shadow tables and returns the response it must give.
   function automatic alloc_rsp_type serve_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [VAL_W-1:0] val);
      alloc_rsp_type     rsp;
      int                count;
      int                pick;
      logic              found;
      logic [SIZE_W-1:0] chosen_size;
      rsp         = '0;
      found       = 1'b0;
      pick        = 0;
      chosen_size = '0;
      case (cmd)
         CMD_LOAD: begin
            current_size[idx]  = val;
            original_size[idx] = val;
         end
         CMD_RESTORE: begin
            for (int i = 0; i < HOLES; i++)
               current_size[i] = original_size[i];
         end
         CMD_ALLOC: begin
            count = (hole_count > HOLES) ? HOLES : hole_count;
            // Only a strictly better hole replaces the first match, so ties stay low.
            for (int i = 0; i < count; i++) begin
               if (current_size[i] >= val) begin
                  if (!found) begin
                     found       = 1'b1;
                     pick        = i;
                     chosen_size = current_size[i];
                  end else if (fit_mode == FIT_BEST && current_size[i] < chosen_size) begin
                     pick        = i;
                     chosen_size = current_size[i];
                  end else if (fit_mode == FIT_WORST && current_size[i] > chosen_size) begin
                     pick        = i;
                     chosen_size = current_size[i];
                  end
               end
            end
            if (found) begin
               current_size[pick] = current_size[pick] - val;
               rsp.granted        = 1'b1;
               rsp.hole_number    = pick[IDX_W-1:0];
               rsp.remaining_size = current_size[pick];
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         fit_mode   = FIT_FIRST;
         hole_count = '0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIT_MODE:   fit_mode   = csr_wdata[MODE_W-1:0];
               CSR_HOLE_COUNT: hole_count = csr_wdata[HCNT_W-1:0];
               default: ;
            endcase
         end
         // A response belongs to an older item than one taken at the same edge.
         if (rsp_valid) begin
            response_tally++;
            if (expected_rsp.size() == 0) begin
               $error("response with no item outstanding: granted %0d hole %0d size %0d",
                      rsp_granted, rsp_hole_number, rsp_remaining_size);
               fail_tally++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.granted)
                  grant_tally++;
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
                  fail_tally++;
               end
               if (rsp_hole_number !== want.hole_number) begin
                  $error("hole_number: expected %0d, actual %0d",
                         want.hole_number, rsp_hole_number);
                  fail_tally++;
               end
               if (rsp_remaining_size !== want.remaining_size) begin
                  $error("remaining_size: expected %0d, actual %0d",
                         want.remaining_size, rsp_remaining_size);
                  fail_tally++;
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(serve_command(req_command, req_hole_index,
                                                 req_size_value));
      end
      mismatch_count <= fail_tally;
      pending_count  <= expected_rsp.size();
      responses_seen <= response_tally;
      grants_seen    <= grant_tally;
   end

endmodule

// ===== sim/contiguous_hole_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the contiguous hole allocator: clock, reset, item and register
// stimulus, a watchdog and the verdict. Depends on cha_pkg, hole_alloc_checker and
// the design files under contiguous_hole_allocator_top.
module contiguous_hole_allocator_top_tb;
   import cha_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The slowest legal gap is
   // a capped sender pause plus a full restore sweep with its drain and commit.
   localparam int STALL_LIMIT = 4000;
   localparam int HOLES       = MAX_HOLES_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = CMD_LOAD;
   logic [IDX_W-1:0]      req_hole_index = '0;
   logic [VAL_W-1:0]      req_size_value = '0;
   logic                  rsp_valid;
   logic                  rsp_granted;
   logic [IDX_W-1:0]      rsp_hole_number;
   logic [VAL_W-1:0]      rsp_remaining_size;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FIT_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int responses_seen;
   int grants_seen;

   // Percentage chance, per cycle, that the sender holds off before its next item.
   int idle_pct = 0;
   int items_sent = 0;
   int loads_sent = 0;
   int restores_sent = 0;
   int allocs_sent = 0;
   int unused_sent = 0;
   int settings_applied = 0;
   int quiet_cycles = 0;

   // Initial hole sizes. Holes 1 and 3 tie for the smallest useful hole and holes 2
   // and 5 tie at full scale, so both tie-break rules get exercised.
   logic [VAL_W-1:0] seed_sizes [HOLES] = '{16'd100, 16'd50, 16'hFFFF, 16'd50,
                                            16'd0, 16'hFFFF, 16'd1, 16'd2,
                                            16'd300, 16'd4000, 16'd5, 16'd60,
                                            16'd7000, 16'd8, 16'd900, 16'd10};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   contiguous_hole_allocator_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_hole_index     (req_hole_index),
      .req_size_value     (req_size_value),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_hole_number    (rsp_hole_number),
      .rsp_remaining_size (rsp_remaining_size),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   hole_alloc_checker rsp_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_hole_index     (req_hole_index),
      .req_size_value     (req_size_value),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_hole_number    (rsp_hole_number),
      .rsp_remaining_size (rsp_remaining_size),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .responses_seen     (responses_seen),
      .grants_seen        (grants_seen)
   );

   // Presents one item and returns at the edge where it is taken. Start is left high
   // so that a following item can go out back to back without a dip.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
      start          <= 1'b1;
      req_command    <= cmd;
      req_hole_index <= idx;
      req_size_value <= val;
      do @(posedge clock); while (busy);
      items_sent++;
      case (cmd)
         CMD_LOAD:    loads_sent++;
         CMD_RESTORE: restores_sent++;
         CMD_ALLOC:   allocs_sent++;
         default:     unused_sent++;
      endcase
   endtask

   // Random hold-off after an item. The gap is geometric, so it lands on every cycle
   // of a restore sweep or a scan, and it is capped to keep the watchdog honest.
   task automatic pace_sender();
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender off until the checker has nothing outstanding. The count it
   // reads is registered in the checker, which only makes the wait longer.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Writes both registers while the block is idle. Valid stays high across the two
   // writes; each is taken at an edge with ready high.
   task automatic write_config(input logic [CSR_DATA_W-1:0] mode_data,
                               input logic [CSR_DATA_W-1:0] count_data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_FIT_MODE;
      csr_wdata <= mode_data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_HOLE_COUNT;
      csr_wdata <= count_data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // One random item. Allocations dominate; request sizes lean small so that holes
   // are carved down over several requests, and restores refill the table now and
   // then so that grants keep coming. Every hole was loaded by the directed part,
   // so no allocation ever reads an unwritten entry.
   task automatic random_item();
      int               roll;
      int               size_roll;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
      roll      = $urandom_range(99);
      size_roll = $urandom_range(99);
      idx       = IDX_W'($urandom_range(HOLES - 1));
      val       = VAL_W'($urandom);
      if (roll < 20) begin
         if (size_roll < 10)
            val = '0;
         else if (size_roll < 20)
            val = '1;
         send_item(CMD_LOAD, idx, val);
      end else if (roll < 28) begin
         send_item(CMD_RESTORE, idx, val);
      end else if (roll < 33) begin
         send_item(CMD_UNUSED, idx, val);
      end else begin
         if (size_roll < 30)
            val = VAL_W'($urandom_range(255));
         else if (size_roll < 60)
            val = VAL_W'($urandom_range(4095));
         else if (size_roll < 70)
            val = '0;
         else if (size_roll < 75)
            val = '1;
         send_item(CMD_ALLOC, idx, val);
      end
   endtask

   // One setting of the registers followed by a stretch of random items. Every 41st
   // item the sender waits for the block to empty out completely.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] mode_data,
                            input logic [CSR_DATA_W-1:0] count_data,
                            input int pct, input int count);
      write_config(mode_data, count_data);
      idle_pct = pct;
      for (int k = 0; k < count; k++) begin
         random_item();
         if ((k % 41) == 40)
            drain_results();
         else
            pace_sender();
      end
   endtask

   // Settings for the closing phases are drawn at random, with junk in the register
   // bits above each field, since the block keeps only the low bits.
   task automatic random_phase(input int count);
      logic [CSR_DATA_W-1:0] mode_junk;
      logic [CSR_DATA_W-1:0] count_junk;
      logic [MODE_W-1:0]     mode;
      logic [HCNT_W-1:0]     holes;
      int                    pct;
      mode_junk  = CSR_DATA_W'($urandom);
      count_junk = CSR_DATA_W'($urandom);
      mode       = MODE_W'($urandom_range(3));
      holes      = HCNT_W'($urandom_range(31));
      case ($urandom_range(2))
         0:       pct = 0;
         1:       pct = 53;
         default: pct = 35;
      endcase
      run_phase({mode_junk[CSR_DATA_W-1:MODE_W], mode},
                {count_junk[CSR_DATA_W-1:HCNT_W], holes}, pct, count);
   endtask

   // Watchdog: any accepted item, register write or response counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding.",
                  STALL_LIMIT, pending_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Right after reset the hole count is zero, so even a zero-size
      // request must be refused, and the unused command code must do nothing.
      send_item(CMD_ALLOC, 4'hF, '0);
      send_item(CMD_UNUSED, 4'hA, 16'h5A5A);
      for (int i = 0; i < HOLES; i++)
         send_item(CMD_LOAD, i[IDX_W-1:0], seed_sizes[i]);

      // First fit over all holes: a zero request lands on hole 0, then full-scale
      // requests use up the two full-scale holes, after which one is refused.
      write_config({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_FIRST}, CSR_DATA_W'(HOLES));
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_ALLOC, '0, '1);
      send_item(CMD_ALLOC, '0, '1);
      send_item(CMD_ALLOC, '0, '1);
      send_item(CMD_RESTORE, '1, '1);

      // Best fit breaks the tie between holes 1 and 3 toward hole 1, and worst fit
      // the tie between the restored full-scale holes toward hole 2.
      write_config({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_BEST}, CSR_DATA_W'(HOLES));
      send_item(CMD_ALLOC, '0, 16'd50);
      write_config({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_WORST}, CSR_DATA_W'(HOLES));
      send_item(CMD_ALLOC, '0, 16'd1);

      // Random part. The fixed phases cover every fit mode, the unused mode code, an
      // oversized hole count that must saturate, a single hole and no holes at all,
      // under each idling pattern, including stretches with no idling.
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_FIRST}, CSR_DATA_W'(HOLES), 0, 70);
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_BEST}, CSR_DATA_W'(HOLES), 53, 70);
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_WORST}, CSR_DATA_W'(HOLES), 35, 70);
      run_phase('1, '1, 0, 50);
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_BEST}, 8'd1, 53, 40);
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_WORST}, 8'd31, 35, 50);
      run_phase({{(CSR_DATA_W-MODE_W){1'b0}}, FIT_FIRST}, 8'd0, 0, 30);
      repeat (3) random_phase(50);

      // Let the last response arrive, then watch a while longer for stray ones.
      drain_results();
      repeat (HOLES + 8) @(posedge clock);

      $display("Sent %0d items (%0d loads, %0d restores, %0d allocations, %0d unused)",
               items_sent, loads_sent, restores_sent, allocs_sent, unused_sent);
      $display("under %0d settings; checked %0d responses, %0d of them granted.",
               settings_applied, responses_seen, grants_seen);
      if (mismatch_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
design/cha_pkg.sv
design/cha_ram.sv
design/cha_fit.sv
design/cha_ctrl.sv
design/contiguous_hole_allocator_top.sv
sim/hole_alloc_checker.sv
sim/contiguous_hole_allocator_top_tb.sv
